// ===== design/i2c_master_bit_sequencer_core_defines.svh =====
// assertion helpers used by the sequencer core module
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_DEFINES_SVH

// condition holds in the same cycle as its trigger
`define I2CMS_ASSERT_SAME(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after its trigger
`define I2CMS_ASSERT_NEXT(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== design/i2cms_pkg.sv =====
package i2cms_pkg;

    // item op codes; the active command uses the same codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_RSTART = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_SEND   = 3'd4;
    localparam logic [2:0] OP_RECV   = 3'd5;
    localparam logic [2:0] OP_CLEAR  = 3'd6;
    localparam logic [2:0] CMD_IDLE  = 3'd0;

    localparam int unsigned TDATA_W = 16;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd2;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    // fields carried in s_tdata, lowest bit last
    typedef struct packed {
        logic       sda_in;
        logic       give_ack;
        logic [7:0] tx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  phase;
        logic [3:0]  bit_cnt;
        logic [15:0] tick_cnt;
        logic [7:0]  shift;
        logic        ack_choice;
        logic        scl;
        logic        sda;
    } seq_state_t;

    // fields carried in m_tdata, lowest bit last
    typedef struct packed {
        logic       rejected;
        logic       line_freed;
        logic [7:0] rx_byte;
        logic       ack_received;
        logic       done_res;
        logic       busy_res;
        logic       sda_level;
        logic       scl_level;
    } result_t;

endpackage

// ===== design/i2cms_step.sv =====
module i2cms_step
    import i2cms_pkg::*;
#(
    parameter int CLEAR_PULSES = 9
) (
    input  logic [2:0]  op,
    input  in_item_t    item,
    input  logic [15:0] half_period,
    input  seq_state_t  st,
    output seq_state_t  st_next,
    output result_t     res
);

    localparam logic [3:0] ClearPulsesW = 4'(CLEAR_PULSES);

    logic [15:0] half_eff;
    logic [16:0] tick_inc;
    logic [3:0]  bit_inc;
    logic        fin;

    always_comb begin
        st_next  = st;
        res      = '0;
        fin      = 1'b0;
        half_eff = (half_period == 16'd0) ? 16'd1 : half_period;
        tick_inc = {1'b0, st.tick_cnt} + 17'd1;
        bit_inc  = st.bit_cnt + 4'd1;

        case (op)
            OP_TICK: begin
                if (st.cmd != CMD_IDLE) begin
                    if (tick_inc >= {1'b0, half_eff}) begin
                        st_next.tick_cnt = '0;
                        case (st.cmd)
                            OP_START: begin
                                if (st.phase == 2'd0) begin
                                    st_next.sda   = 1'b0;
                                    st_next.phase = 2'd1;
                                end else begin
                                    st_next.scl = 1'b0;
                                    fin         = 1'b1;
                                end
                            end
                            OP_RSTART: begin
                                if (st.phase == 2'd0) begin
                                    st_next.scl   = 1'b1;
                                    st_next.phase = 2'd1;
                                end else if (st.phase == 2'd1) begin
                                    st_next.sda   = 1'b0;
                                    st_next.phase = 2'd2;
                                end else begin
                                    st_next.scl = 1'b0;
                                    fin         = 1'b1;
                                end
                            end
                            OP_STOP: begin
                                if (st.phase == 2'd0) begin
                                    st_next.scl   = 1'b1;
                                    st_next.phase = 2'd1;
                                end else begin
                                    st_next.sda = 1'b1;
                                    fin         = 1'b1;
                                end
                            end
                            OP_SEND: begin
                                if (st.phase == 2'd0 || st.phase == 2'd2) begin
                                    st_next.scl   = 1'b1;
                                    st_next.phase = st.phase + 2'd1;
                                end else if (st.phase == 2'd1) begin
                                    st_next.scl     = 1'b0;
                                    st_next.bit_cnt = bit_inc;
                                    st_next.shift   = {st.shift[6:0], 1'b0};
                                    if (bit_inc < BITS_PER_BYTE) begin
                                        st_next.sda   = st.shift[6];
                                        st_next.phase = 2'd0;
                                    end else begin
                                        st_next.sda   = 1'b1;
                                        st_next.phase = 2'd2;
                                    end
                                end else begin
                                    // ack slot: slave holds sda low to acknowledge
                                    res.ack_received = ~item.sda_in;
                                    st_next.scl      = 1'b0;
                                    st_next.sda      = 1'b0;
                                    fin              = 1'b1;
                                end
                            end
                            OP_RECV: begin
                                if (st.phase == 2'd0 || st.phase == 2'd2) begin
                                    st_next.scl   = 1'b1;
                                    st_next.phase = st.phase + 2'd1;
                                end else if (st.phase == 2'd1) begin
                                    st_next.shift   = {st.shift[6:0], item.sda_in};
                                    st_next.scl     = 1'b0;
                                    st_next.bit_cnt = bit_inc;
                                    if (bit_inc < BITS_PER_BYTE) begin
                                        st_next.phase = 2'd0;
                                    end else begin
                                        st_next.sda   = ~st.ack_choice;
                                        st_next.phase = 2'd2;
                                    end
                                end else begin
                                    st_next.scl = 1'b0;
                                    res.rx_byte = st.shift;
                                    fin         = 1'b1;
                                end
                            end
                            OP_CLEAR: begin
                                if (st.phase == 2'd0) begin
                                    if (item.sda_in) begin
                                        res.line_freed = 1'b1;
                                        fin            = 1'b1;
                                    end else begin
                                        st_next.scl   = 1'b0;
                                        st_next.phase = 2'd1;
                                    end
                                end else begin
                                    st_next.scl     = 1'b1;
                                    st_next.bit_cnt = bit_inc;
                                    if (bit_inc >= ClearPulsesW) begin
                                        fin = 1'b1;
                                    end else begin
                                        st_next.phase = 2'd0;
                                    end
                                end
                            end
                            default: begin
                                fin = 1'b1;
                            end
                        endcase
                        if (fin) begin
                            st_next.cmd   = CMD_IDLE;
                            st_next.phase = 2'd0;
                            res.done_res  = 1'b1;
                        end
                    end else begin
                        st_next.tick_cnt = tick_inc[15:0];
                    end
                end
            end
            OP_START, OP_RSTART, OP_STOP, OP_SEND, OP_RECV, OP_CLEAR: begin
                if (st.cmd != CMD_IDLE) begin
                    res.rejected = 1'b1;
                end else begin
                    st_next.cmd      = op;
                    st_next.phase    = 2'd0;
                    st_next.bit_cnt  = '0;
                    st_next.tick_cnt = '0;
                    case (op)
                        OP_START: begin
                            st_next.scl = 1'b1;
                            st_next.sda = 1'b1;
                        end
                        OP_RSTART: begin
                            st_next.scl = 1'b0;
                            st_next.sda = 1'b1;
                        end
                        OP_STOP: begin
                            st_next.sda = 1'b0;
                        end
                        OP_SEND: begin
                            st_next.shift = item.tx_byte;
                            st_next.sda   = item.tx_byte[7];
                        end
                        OP_RECV: begin
                            st_next.shift      = '0;
                            st_next.ack_choice = item.give_ack;
                            st_next.sda        = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                // unused op code: the state is left unchanged
            end
        endcase

        res.scl_level = st_next.scl;
        res.sda_level = st_next.sda;
        res.busy_res  = (st_next.cmd != CMD_IDLE);
    end

endmodule

// ===== design/i2c_master_bit_sequencer_core.sv =====
// an item taken on s_* is held in the input stage, and its result is registered in the result stage for m_tdata
// throughput: one item per clock while the output is not stalled; the phase state is updated by one short step per item
// s_tready follows m_tready through a single input stage, so a stalled output holds one item
// reset: synchronous active-low aresetn clears both stage valids, sets the command idle,
// counters and shift register to zero, scl and sda released high, half period to 2
`include "i2c_master_bit_sequencer_core_defines.svh"

module i2c_master_bit_sequencer_core
    import i2cms_pkg::*;
#(
    parameter int CLEAR_PULSES = 9
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input items
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // tx_byte[7:0], give_ack[8], sda_in[9], zero pad
    input  logic [2:0]         s_tuser,   // op[2:0]
    // result items
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // scl_level, sda_level, busy_res, done_res,
                                          // ack_received, rx_byte[12:5], line_freed,
                                          // rejected[14], zero pad
    // half period register write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data   // half_period_ticks
);

    // input stage
    logic       in_valid_reg;
    logic [2:0] in_op_reg;
    in_item_t   in_item_reg;

    // sequencer state and result stage
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    step_res;
    logic       out_valid_reg;
    result_t    out_data_reg;
    logic [15:0] half_period_reg;

    logic advance;   // result stage can take a new value
    logic proc;      // the registered item is processed this cycle
    logic s_accept;

    assign advance   = ~out_valid_reg | m_tready;
    assign proc      = in_valid_reg & advance;
    assign s_tready  = ~in_valid_reg | advance;
    assign s_accept  = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - $bits(result_t)){1'b0}}, out_data_reg};

    i2cms_step #(
        .CLEAR_PULSES(CLEAR_PULSES)
    ) u_step (
        .op         (in_op_reg),
        .item       (in_item_reg),
        .half_period(half_period_reg),
        .st         (state_reg),
        .st_next    (state_next),
        .res        (step_res)
    );

    // configuration register; the user must write it only between commands, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            half_period_reg <= cfg_data;
        end
    end

    // input stage: holds one item until the step logic can use it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg   <= s_tuser;
            in_item_reg <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
        end
    end

    // sequencer state moves only when an item is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.cmd        <= CMD_IDLE;
            state_reg.phase      <= 2'd0;
            state_reg.bit_cnt    <= '0;
            state_reg.tick_cnt   <= '0;
            state_reg.shift      <= '0;
            state_reg.ack_choice <= 1'b0;
            state_reg.scl        <= 1'b1;
            state_reg.sda        <= 1'b1;
        end else if (proc) begin
            state_reg <= state_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_data_reg <= step_res;
        end
    end

    // a processed item always shows up at the output next cycle
    `I2CMS_ASSERT_NEXT(a_proc_to_out, aclk, aresetn, proc, out_valid_reg,
        "processed item did not reach the result stage")
    // a finished command leaves the sequencer idle
    `I2CMS_ASSERT_SAME(a_done_idle, aclk, aresetn, out_valid_reg && out_data_reg.done_res,
        !out_data_reg.busy_res && !out_data_reg.rejected, "done result still busy or rejected")
    // per-command status bits only come with a done
    `I2CMS_ASSERT_SAME(a_status_done, aclk, aresetn,
        out_valid_reg && (out_data_reg.ack_received || out_data_reg.line_freed),
        out_data_reg.done_res, "command status without done")
    // a rejected command leaves the sequencer busy
    `I2CMS_ASSERT_SAME(a_reject_busy, aclk, aresetn, out_valid_reg && out_data_reg.rejected,
        out_data_reg.busy_res, "reject reported while idle")

endmodule
